>>> hdl/pglb_pkg.sv
package pglb_pkg;

  // Chain geometry
  localparam int NUM_DRIVERS = 4;
  localparam int CHANNELS    = NUM_DRIVERS * 16;
  localparam int PAIRS       = NUM_DRIVERS * 8;
  localparam int ADDR_W      = $clog2(CHANNELS);
  localparam int PTR_W       = $clog2(PAIRS);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int CHAN_W  = 8;
  localparam int LEVEL_W = 12;
  localparam int BYTE_W  = 8;

  // Queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OQ_DEPTH   = 2;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_SHIFT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_OOR   = 3'd2,
    OP_FILL  = 3'd3,
    OP_SHIFT = 3'd4
  } op_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] read_level;
    logic               out_of_range;
    logic [BYTE_W-1:0]  serial_byte;
    logic               is_serial;
    logic               frame_last;
  } res_t;

endpackage

>>> hdl/pglb_ram.sv
module pglb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/pglb_front.sv
module pglb_front
  import pglb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [KIND_W-1:0]  kind,
  input  logic [CHAN_W-1:0]  channel,
  input  logic [LEVEL_W-1:0] level,
  input  logic               cq_full,
  output logic               cq_push,
  output cmd_t               cq_din
);

  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic              in_range;
  logic              keep;
  logic              accept;
  logic              last;
  logic [ADDR_W-1:0] sh_a;
  logic [ADDR_W-1:0] sh_b;
  kind_t             kind_q;

  assign kind_q   = kind_t'(kind);
  assign accept   = push && !cq_full;
  assign full     = cq_full;
  assign in_range = {1'b0, channel} < (CHAN_W + 1)'(CHANNELS);

  // pair p: first = CH-1-2p (odd), second = CH-2-2p
  assign sh_a = ADDR_W'(CHANNELS - 1) - {ptr_r, 1'b0};
  assign sh_b = {sh_a[ADDR_W-1:1], 1'b0};
  assign last = (ptr_r == PTR_W'(PAIRS - 1));

  always_comb begin
    keep          = 1'b1;
    cq_din.op     = OP_WRITE;
    cq_din.addr_a = channel[ADDR_W-1:0];
    cq_din.addr_b = sh_b;
    cq_din.level  = level;
    cq_din.last   = last;
    unique case (kind_q)
      KIND_WRITE: begin
        keep = in_range;
      end
      KIND_READ: begin
        cq_din.op = in_range ? OP_READ : OP_OOR;
      end
      KIND_FILL: begin
        cq_din.op = OP_FILL;
      end
      KIND_SHIFT: begin
        cq_din.op     = OP_SHIFT;
        cq_din.addr_a = sh_a;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cq_push = accept && keep;

  always_comb begin
    ptr_nxt = ptr_r;
    if (accept && kind_q == KIND_SHIFT) begin
      ptr_nxt = last ? '0 : ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

endmodule

>>> hdl/pglb_cmdq.sv
module pglb_cmdq
  import pglb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, wp_nxt;
  logic [CMDQ_AW-1:0] rp_r, rp_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + CMDQ_AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + CMDQ_AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CMDQ_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

>>> hdl/pglb_back.sv
module pglb_back
  import pglb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cq_dout,
  input  logic cq_empty,
  output logic cq_pop,
  output res_t res,
  output logic empty,
  input  logic pop
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SHA,
    S_E0,
    S_E1,
    S_E2
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [LEVEL_W-1:0] a_r, a_nxt;

  // level store: RAM plus per-channel valid bits; invalid reads as fill level
  logic [CHANNELS-1:0] vld_r;
  logic [LEVEL_W-1:0]  fill_r;
  logic                rd_vld_r;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [LEVEL_W-1:0]  ram_rdata;
  logic                fill_we;
  logic [LEVEL_W-1:0]  store_val;

  // result queue
  res_t             oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_CW-1:0] oq_cnt_r;
  logic             oq_full;
  logic             oq_push;
  logic             oq_pop;
  res_t             oq_din;

  pglb_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cq_dout.addr_a),
    .wdata (cq_dout.level),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign store_val = rd_vld_r ? ram_rdata : fill_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    a_nxt     = a_r;
    cq_pop    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = cq_dout.addr_a;
    fill_we   = 1'b0;
    oq_push   = 1'b0;
    oq_din    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!cq_empty) begin
          unique case (cq_dout.op)
            OP_WRITE: begin
              ram_we = 1'b1;
              cq_pop = 1'b1;
            end
            OP_FILL: begin
              fill_we = 1'b1;
              cq_pop  = 1'b1;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              cq_pop    = 1'b1;
              state_nxt = S_RD;
            end
            OP_OOR: begin
              if (!oq_full) begin
                oq_push             = 1'b1;
                oq_din.out_of_range = 1'b1;
                cq_pop              = 1'b1;
              end
            end
            OP_SHIFT: begin
              ram_re    = 1'b1;
              cq_pop    = 1'b1;
              cmd_nxt   = cq_dout;
              state_nxt = S_SHA;
            end
            default: begin
              cq_pop = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        if (!oq_full) begin
          oq_push           = 1'b1;
          oq_din.read_level = store_val;
          state_nxt         = S_IDLE;
        end
      end
      S_SHA: begin
        a_nxt     = store_val;
        ram_re    = 1'b1;
        ram_raddr = cmd_r.addr_b;
        state_nxt = S_E0;
      end
      S_E0: begin
        if (!oq_full) begin
          oq_push            = 1'b1;
          oq_din.is_serial   = 1'b1;
          oq_din.serial_byte = a_r[11:4];
          state_nxt          = S_E1;
        end
      end
      S_E1: begin
        if (!oq_full) begin
          oq_push            = 1'b1;
          oq_din.is_serial   = 1'b1;
          oq_din.serial_byte = {a_r[3:0], store_val[11:8]};
          state_nxt          = S_E2;
        end
      end
      S_E2: begin
        if (!oq_full) begin
          oq_push            = 1'b1;
          oq_din.is_serial   = 1'b1;
          oq_din.serial_byte = store_val[7:0];
          oq_din.frame_last  = cmd_r.last;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
    a_r   <= a_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      fill_r <= '0;
    end else if (fill_we) begin
      vld_r  <= '0;
      fill_r <= cq_dout.level;
    end else if (ram_we) begin
      vld_r[cq_dout.addr_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
  end

  // result queue
  assign oq_full = (oq_cnt_r == OQ_CW'(OQ_DEPTH));
  assign empty   = (oq_cnt_r == '0);
  assign oq_pop  = pop && !empty;
  assign res     = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= (oq_wp_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wp_r + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rp_r <= (oq_rp_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rp_r + OQ_AW'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + OQ_CW'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - OQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= oq_din;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("result pushed into full queue");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> (state_r == S_IDLE) && !cq_empty)
    else $error("command taken outside idle");

  a_sha_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHA |=> state_r == S_E0)
    else $error("second read of pair not followed by first byte");

  a_last_serial: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push && oq_din.frame_last |-> oq_din.is_serial && state_r == S_E2)
    else $error("frame end flagged on a non-final byte");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= OQ_CW'(OQ_DEPTH))
    else $error("result queue count overflow");

endmodule

>>> hdl/packed_grayscale_led_buffer.sv
// Packed 12-bit grayscale buffer for a chain of LED drivers (16 channels each).
//
// Input side is a queue: drive in_kind/in_channel/in_level and raise push;
// the item transfers on a clock edge with push high and full low. Kinds are
// write channel, read channel, fill all channels, and shift next pair.
// Result side is a queue too: while empty is low the oldest result sits on
// the out_ ports; it transfers on an edge with pop high.
//
// A front stage classifies each item (range check, pair address) and owns
// the pair pointer; a two-entry command queue decouples it from the back
// stage, which owns the level store (RAM with one write and one registered
// read port) and a two-entry result queue. Writes and fills finish in the
// idle state; a read's result passes the command queue, the registered RAM
// read and the result queue; a shift makes two RAM reads through the one
// read port, then queues one byte per cycle while the result queue has room.
// Fill clears the per-channel valid bits and records the fill level.
// Reset (synchronous, rst_n low) empties both queues, zeroes the pair
// pointer and makes every channel read as zero; no clearing sweep is needed.
// If the receiver stalls, the result queue fills, the back stage holds, and
// full rises once the command queue is also full; nothing is dropped.
module packed_grayscale_led_buffer
  import pglb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [CHAN_W-1:0]  in_channel,
  input  logic [LEVEL_W-1:0] in_level,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic [LEVEL_W-1:0] out_read_level,
  output logic               out_out_of_range,
  output logic [BYTE_W-1:0]  out_serial_byte,
  output logic               out_is_serial,
  output logic               out_frame_last
);

  // front -> command queue
  cmd_t cq_din;
  logic cq_push;
  logic cq_full;
  // command queue -> back
  cmd_t cq_dout;
  logic cq_pop;
  logic cq_empty;
  // back -> result ports
  res_t res;

  pglb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .kind    (in_kind),
    .channel (in_channel),
    .level   (in_level),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_din  (cq_din)
  );

  pglb_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .din   (cq_din),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty)
  );

  // store, sequencer and result queue
  pglb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_dout  (cq_dout),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .res      (res),
    .empty    (empty),
    .pop      (pop)
  );

  assign out_read_level   = res.read_level;
  assign out_out_of_range = res.out_of_range;
  assign out_serial_byte  = res.serial_byte;
  assign out_is_serial    = res.is_serial;
  assign out_frame_last   = res.frame_last;

endmodule

>>> verif/tb_packed_grayscale_led_buffer.sv
`timescale 1ns / 100ps

module tb_packed_grayscale_led_buffer;
  import pglb_pkg::*;

  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off in the backpressure test
  localparam int SETTLE_CYCLES = 20;      // quiet time after the last result
  localparam int MAX_PRINTED  = 50;       // mismatch lines shown before going quiet

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // Input queue side; every input starts at a known value
  logic               push       = 1'b0;
  logic [KIND_W-1:0]  in_kind    = '0;
  logic [CHAN_W-1:0]  in_channel = '0;
  logic [LEVEL_W-1:0] in_level   = '0;
  logic               full;

  // Result queue side
  logic               pop = 1'b0;
  logic               empty;
  logic [LEVEL_W-1:0] out_read_level;
  logic               out_out_of_range;
  logic [BYTE_W-1:0]  out_serial_byte;
  logic               out_is_serial;
  logic               out_frame_last;

  packed_grayscale_led_buffer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_kind          (in_kind),
    .in_channel       (in_channel),
    .in_level         (in_level),
    .empty            (empty),
    .pop              (pop),
    .out_read_level   (out_read_level),
    .out_out_of_range (out_out_of_range),
    .out_serial_byte  (out_serial_byte),
    .out_is_serial    (out_is_serial),
    .out_frame_last   (out_frame_last)
  );

  // Mirror of the block's state: one level per channel and the next pair to shift.
  // Both come up zero, as the block does after reset.
  logic [LEVEL_W-1:0] level_mirror [CHANNELS];
  logic [PTR_W-1:0]   pair_mirror;
  res_t               pending_results [$];   // results predicted but not yet popped

  // Idle rates in percent; rx side is read by the pop driver
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Receiver hold-off: the test bumps hold_req, the counter below runs it out
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  // Run statistics
  int error_count       = 0;
  int n_items           = 0;
  int n_oor_reads       = 0;
  int n_fills           = 0;
  int n_results         = 0;
  int n_frame_ends      = 0;
  int full_stall_cycles = 0;
  int n_holds           = 0;

  initial begin
    foreach (level_mirror[i]) level_mirror[i] = '0;
    pair_mirror = '0;
  end

  task automatic flag_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic res_t serial_result(logic [BYTE_W-1:0] b, logic last);
    res_t r;
    r              = '0;
    r.serial_byte  = b;
    r.is_serial    = 1'b1;
    r.frame_last   = last;
    return r;
  endfunction

  // Work out what one transferred item does: update the mirror and queue the
  // results it should produce (none, one read result, or three serial bytes).
  function automatic void predict_led_results(kind_t k, logic [CHAN_W-1:0] ch,
                                              logic [LEVEL_W-1:0] lvl);
    res_t               r;
    logic [LEVEL_W-1:0] first_lvl;
    logic [LEVEL_W-1:0] second_lvl;
    logic               wraps;
    logic [ADDR_W-1:0]  hi_ch;
    r = '0;
    case (k)
      KIND_WRITE: begin
        // writes past the end of the chain are dropped silently
        if (ch < CHANNELS) level_mirror[ch[ADDR_W-1:0]] = lvl;
      end
      KIND_READ: begin
        if (ch < CHANNELS) begin
          r.read_level = level_mirror[ch[ADDR_W-1:0]];
        end else begin
          r.out_of_range = 1'b1;
          n_oor_reads++;
        end
        pending_results.push_back(r);
      end
      KIND_FILL: begin
        foreach (level_mirror[i]) level_mirror[i] = lvl;
        n_fills++;
      end
      KIND_SHIFT: begin
        // highest channel goes first; pair p is channels CH-1-2p and CH-2-2p
        hi_ch      = ADDR_W'(CHANNELS - 1) - {pair_mirror, 1'b0};
        first_lvl  = level_mirror[hi_ch];
        second_lvl = level_mirror[hi_ch - ADDR_W'(1)];
        wraps      = (pair_mirror == PTR_W'(PAIRS - 1));
        pending_results.push_back(serial_result(first_lvl[11:4], 1'b0));
        pending_results.push_back(serial_result({first_lvl[3:0], second_lvl[11:8]},
                                                1'b0));
        pending_results.push_back(serial_result(second_lvl[7:0], wraps));
        pair_mirror = wraps ? '0 : pair_mirror + PTR_W'(1);
      end
      default: ;
    endcase
  endfunction

  // Offer one item and hold it until it transfers. Entered and left at a rising
  // edge; push stays high on exit so back-to-back items need no gap.
  task automatic send_item(kind_t k, logic [CHAN_W-1:0] ch, logic [LEVEL_W-1:0] lvl);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_kind    <= k;
    in_channel <= ch;
    in_level   <= lvl;
    @(posedge clk);
    while (full) begin
      full_stall_cycles++;
      @(posedge clk);
    end
    n_items++;
    predict_led_results(k, ch, lvl);
  endtask

  // Sender pauses until every predicted result has been popped
  task automatic wait_for_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly in-range channels with random levels; a few out-of-range channels,
  // all-zero and full-scale levels. Shifts are frequent so the frame wraps often.
  task automatic send_random_item();
    int                 pick;
    kind_t              k;
    logic [CHAN_W-1:0]  ch;
    logic [LEVEL_W-1:0] lvl;
    pick = $urandom_range(0, 99);
    if (pick < 33)      k = KIND_WRITE;
    else if (pick < 58) k = KIND_READ;
    else if (pick < 61) k = KIND_FILL;
    else                k = KIND_SHIFT;
    if ($urandom_range(0, 9) < 8) ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
    else                          ch = CHAN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       lvl = '0;
      1:       lvl = '1;
      default: lvl = LEVEL_W'($urandom_range(0, 4095));
    endcase
    send_item(k, ch, lvl);
  endtask

  // Reset contents, range checks, byte packing and fill, one item at a time
  task automatic test_directed_ops();
    tx_idle_pct = 10;
    rx_idle_pct <= 30;
    send_item(KIND_READ,  8'd0,   12'hFFF);     // store comes up zero
    send_item(KIND_READ,  8'd63,  12'h000);
    send_item(KIND_READ,  8'd64,  12'h000);     // first channel past the chain
    send_item(KIND_READ,  8'd255, 12'hFFF);     // far past the chain
    send_item(KIND_WRITE, 8'd0,   12'hFFF);
    send_item(KIND_WRITE, 8'd63,  12'hABC);
    send_item(KIND_WRITE, 8'd62,  12'h123);
    send_item(KIND_WRITE, 8'd64,  12'h555);     // dropped
    send_item(KIND_WRITE, 8'd255, 12'h777);     // dropped
    send_item(KIND_READ,  8'd63,  12'h000);
    send_item(KIND_READ,  8'd62,  12'h000);
    send_item(KIND_READ,  8'd0,   12'h000);
    send_item(KIND_SHIFT, 8'd0,   12'h000);     // pair 0: AB C1 23
    send_item(KIND_FILL,  8'd200, 12'h5A5);
    send_item(KIND_READ,  8'd17,  12'h000);
    send_item(KIND_SHIFT, 8'hFF,  12'hFFF);     // pointer left alone by the fill
    send_item(KIND_FILL,  8'd0,   12'h000);
    send_item(KIND_READ,  8'd1,   12'h000);
    send_item(KIND_WRITE, 8'd60,  12'hFFF);
    send_item(KIND_WRITE, 8'd59,  12'h000);
    send_item(KIND_SHIFT, 8'd0,   12'h000);
    wait_for_results();
  endtask

  // Receiver stops for a long stretch while the sender keeps offering mostly shifts,
  // so both internal queues fill and full rises.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= hold_req + 1;
    n_holds++;
    for (int i = 0; i < 24; i++) begin
      if (i % 4 == 3) send_random_item();
      else            send_item(KIND_SHIFT, CHAN_W'($urandom), LEVEL_W'($urandom));
    end
    wait_for_results();
  endtask

  task automatic test_random(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (n) send_random_item();
    wait_for_results();
  endtask

  // Hold-off counter for the receiver
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end
  end

  // Result checker and pop driver. A result transfers at an edge where pop was
  // high and empty low; the values read here are the ones before the edge.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && pop && !empty) begin
      n_results++;
      if (out_frame_last === 1'b1) n_frame_ends++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending (serial %b byte %02h)",
                                out_is_serial, out_serial_byte));
      end else begin
        want = pending_results.pop_front();
        if (out_read_level !== want.read_level)
          flag_mismatch($sformatf("read_level %03h, expected %03h",
                                  out_read_level, want.read_level));
        if (out_out_of_range !== want.out_of_range)
          flag_mismatch($sformatf("out_of_range %b, expected %b",
                                  out_out_of_range, want.out_of_range));
        if (out_serial_byte !== want.serial_byte)
          flag_mismatch($sformatf("serial_byte %02h, expected %02h",
                                  out_serial_byte, want.serial_byte));
        if (out_is_serial !== want.is_serial)
          flag_mismatch($sformatf("is_serial %b, expected %b",
                                  out_is_serial, want.is_serial));
        if (out_frame_last !== want.frame_last)
          flag_mismatch($sformatf("frame_last %b, expected %b",
                                  out_frame_last, want.frame_last));
      end
    end
    pop <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_backpressure();
    test_random(170, 32, 79);   // slow sender, very slow receiver
    test_random(170, 79, 32);   // the other way round
    test_random(170, 0, 0);     // both sides at full rate
    push <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Covered %0d items (%0d fills, %0d out-of-range reads),",
             n_items, n_fills, n_oor_reads);
    $display("  %0d results checked, %0d frame ends, %0d full cycles, %0d hold(s).",
             n_results, n_frame_ends, full_stall_cycles, n_holds);
    if (error_count == 0) begin
      $display("tb_packed_grayscale_led_buffer: clean");
    end else begin
      $display("tb_packed_grayscale_led_buffer: errors");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timeout with %0d results pending", pending_results.size());
    $display("tb_packed_grayscale_led_buffer: errors");
    $finish;
  end

endmodule

>>> packed_grayscale_led_buffer.f
hdl/pglb_pkg.sv
hdl/pglb_ram.sv
hdl/pglb_front.sv
hdl/pglb_cmdq.sv
hdl/pglb_back.sv
hdl/packed_grayscale_led_buffer.sv
verif/tb_packed_grayscale_led_buffer.sv
